FILE: hw/rtl/gbvu_pkg.sv
// Shared constants, types and helpers of the greedy bandit value update block.
// No dependencies; every other file imports this package.

package gbvu_pkg;

	localparam int NUM_ARMS  = 16;
	localparam int ARM_W     = $clog2(NUM_ARMS);
	localparam int ARM_OUT_W = 4;
	localparam int Q_W       = 24;
	localparam int STEP_W    = 17;
	localparam int DIFF_W    = Q_W + 1;
	localparam int PROD_W    = DIFF_W + STEP_W + 1;
	localparam int FRAC_W    = 16;
	localparam int SUM_W     = PROD_W - FRAC_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = CFG_IDX_W'(1);

	localparam logic FUNC_REWARD  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6554);

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic [ARM_W-1:0]      arm_t;
	typedef logic [STEP_W-1:0]     step_t;

	typedef struct packed {
		logic shift;
		q_t   head_new;
	} chain_ctl_t;

	function automatic logic [ARM_OUT_W-1:0] arm_to_out(input arm_t a);
		logic [ARM_W+ARM_OUT_W-1:0] t;
		t = {{ARM_OUT_W{1'b0}}, a};
		return t[ARM_OUT_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/gbvu_item_if.sv
// Input channel of the greedy bandit block: valid/ready plus one item.
// Depends on gbvu_pkg.

interface gbvu_item_if;
	import gbvu_pkg::*;

	logic valid;
	logic ready;
	logic func;
	q_t   reward;

	modport source(output valid, output func, output reward, input ready);
	modport sink(input valid, input func, input reward, output ready);
endinterface

FILE: hw/rtl/gbvu_result_if.sv
// Output channel of the greedy bandit block: valid/ready plus one result.
// Depends on gbvu_pkg.

interface gbvu_result_if;
	import gbvu_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ARM_OUT_W-1:0] chosen_arm;
	q_t                   chosen_value;

	modport source(output valid, output chosen_arm, output chosen_value, input ready);
	modport sink(input valid, input chosen_arm, input chosen_value, output ready);
endinterface

FILE: hw/rtl/gbvu_cell.sv
// One cell of the value ring: holds a single arm estimate and passes it on.
// Depends on gbvu_pkg.

module gbvu_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  gbvu_pkg::q_t  d,
	output gbvu_pkg::q_t  q
);
	import gbvu_pkg::*;

	q_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;
endmodule

FILE: hw/rtl/gbvu_ctrl.sv
// Sequencer of the greedy bandit block: config registers, update arithmetic,
// ring rotation and running argmax over the head cell. Depends on gbvu_pkg
// and the two channel interfaces.

module gbvu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	gbvu_item_if.sink                     item,
	gbvu_result_if.source                 result,
	input  logic                          wr_en,
	input  logic [gbvu_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [gbvu_pkg::Q_W-1:0]      wr_data,
	input  gbvu_pkg::q_t                  head,
	output gbvu_pkg::chain_ctl_t          ctl
);
	import gbvu_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_SCAN, S_PUB} state_t;

	state_t                state_q;
	q_t                    init_q;
	step_t                 step_q;
	logic                  func_q;
	q_t                    reward_q;
	q_t                    lastq_q;
	arm_t                  last_arm_q;
	logic signed [PROD_W-1:0] prod_s1;
	q_t                    newq_s2;
	arm_t                  idx_q;
	q_t                    best_val_q;
	arm_t                  best_idx_q;
	logic                  out_valid_q;
	logic [ARM_OUT_W-1:0]  out_arm_q;
	q_t                    out_val_q;

	logic signed [DIFF_W-1:0]   diff_c;
	logic signed [STEP_W:0]     step_ext_c;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [SUM_W-1:0]    sum_c;
	q_t                         sat_c;
	q_t                         head_new_c;
	logic                       pub_c;

	always_comb begin
		diff_c     = DIFF_W'(reward_q) - DIFF_W'(lastq_q);
		step_ext_c = $signed({1'b0, step_q});
		prod_c     = diff_c * step_ext_c;
		sum_c      = SUM_W'(lastq_q) + SUM_W'($signed(prod_s1[PROD_W-1:FRAC_W]));
		if (sum_c[SUM_W-1:Q_W-1] == '0 || sum_c[SUM_W-1:Q_W-1] == '1) begin
			sat_c = sum_c[Q_W-1:0];
		end else if (sum_c[SUM_W-1]) begin
			sat_c = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(Q_W-1){1'b1}}};
		end
		if (func_q == FUNC_RESTART) begin
			head_new_c = init_q;
		end else if (idx_q == last_arm_q) begin
			head_new_c = newq_s2;
		end else begin
			head_new_c = head;
		end
	end

	assign pub_c = (state_q == S_PUB) && (!out_valid_q || result.ready);

	assign ctl.shift    = (state_q == S_SCAN);
	assign ctl.head_new = head_new_c;

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.chosen_arm   = out_arm_q;
	assign result.chosen_value = out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			init_q      <= '0;
			step_q      <= STEP_RESET;
			func_q      <= FUNC_REWARD;
			reward_q    <= '0;
			lastq_q     <= '0;
			last_arm_q  <= '0;
			prod_s1     <= '0;
			newq_s2     <= '0;
			idx_q       <= '0;
			best_val_q  <= '0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_arm_q   <= '0;
			out_val_q   <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_INITIAL_VALUE: init_q <= wr_data;
					REG_STEP_SIZE:     step_q <= wr_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (pub_c) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						func_q   <= item.func;
						reward_q <= item.reward;
						idx_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s1 <= prod_c;
					state_q <= S_ADD;
				end
				S_ADD: begin
					newq_s2 <= sat_c;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == '0 || head_new_c > best_val_q) begin
						best_val_q <= head_new_c;
						best_idx_q <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == ARM_W'(NUM_ARMS - 1)) begin
						state_q <= S_PUB;
					end
				end
				S_PUB: begin
					if (pub_c) begin
						out_arm_q   <= arm_to_out(best_idx_q);
						out_val_q   <= best_val_q;
						last_arm_q  <= best_idx_q;
						lastq_q     <= best_val_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/greedy_bandit_value_update.sv
// Top level of the greedy bandit value update block: ring of value cells
// and its sequencer. Depends on gbvu_pkg, the channel interfaces, gbvu_cell
// and gbvu_ctrl.

// Greedy bandit agent with optimistic start values. Arm estimates sit in a
// ring of NUM_ARMS cells; each item rotates the ring once, one arm per cycle,
// rewriting the arm chosen last (reward beat) or every arm (restart beat)
// as it passes the head and keeping a running maximum, lowest index on ties.
// Each item steps through the idle state, which accepts the beat, the
// multiply state, the saturating add state, the rotation over all arms
// and finally the publish state, which writes the result into the
// output register. A result waits in that register without holding up the
// next beat's acceptance; the following result then waits in the publish
// step until the held one is taken. No clearing pass after reset.
// Config writes: index 0 initial_value, 1 step_size.

module greedy_bandit_value_update (
	input  logic                           clk,
	input  logic                           arst_n,
	gbvu_item_if.sink                      item,
	gbvu_result_if.source                  result,
	input  logic                           wr_en,
	input  logic [gbvu_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [gbvu_pkg::Q_W-1:0]       wr_data
);
	import gbvu_pkg::*;

	chain_ctl_t ctl;
	q_t         cell_q [NUM_ARMS];

	gbvu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.head     (cell_q[0]),
		.ctl      (ctl)
	);

	for (genvar i = 0; i < NUM_ARMS; i++) begin : g_cell
		if (i == NUM_ARMS - 1) begin : g_tail
			gbvu_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ctl.shift),
				.d      (ctl.head_new),
				.q      (cell_q[i])
			);
		end else begin : g_body
			gbvu_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ctl.shift),
				.d      (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of greedy_bandit_value_update: random and directed
// reward/restart beats against a built-in predictor. Needs gbvu_pkg and both channel interfaces.

module tb_top;
	import gbvu_pkg::*;

	localparam q_t Q_LOW          = q_t'(-8388608);
	localparam q_t Q_HIGH         = q_t'(8388607);
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [ARM_OUT_W-1:0] arm;
		q_t                   value;
	} pick_t;

	class bandit_tracker;
		q_t    values[NUM_ARMS];
		int    last_pick;
		q_t    start_value;
		step_t alpha;
		pick_t pending[$];
		int    mismatches;

		function new();
			foreach (values[i]) values[i] = '0;
			last_pick   = 0;
			start_value = '0;
			alpha       = STEP_RESET;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
			case (idx)
				REG_INITIAL_VALUE: start_value = q_t'(data);
				REG_STEP_SIZE:     alpha = data[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic f, q_t r);
			longint gap;
			longint scaled;
			longint sum;
			int     best;
			pick_t  p;
			if (f == FUNC_RESTART) begin
				foreach (values[i]) values[i] = start_value;
			end else begin
				gap    = longint'(r) - longint'(values[last_pick]);
				scaled = gap * longint'(alpha);
				sum    = longint'(values[last_pick]) + (scaled >>> FRAC_W);
				if (sum < longint'(Q_LOW))
					sum = longint'(Q_LOW);
				else if (sum > longint'(Q_HIGH))
					sum = longint'(Q_HIGH);
				values[last_pick] = q_t'(sum);
			end
			best = 0;
			for (int i = 1; i < NUM_ARMS; i++) begin
				if (values[i] > values[best])
					best = i;
			end
			last_pick = best;
			p.arm     = ARM_OUT_W'(best);
			p.value   = values[best];
			pending.push_back(p);
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_pick(logic [ARM_OUT_W-1:0] arm, q_t value);
			pick_t p;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result arm %0d value %0d", arm, value));
			end else begin
				p = pending.pop_front();
				if (arm !== p.arm)
					report($sformatf("chosen_arm %0d, expected %0d", arm, p.arm));
				if (value !== p.value)
					report($sformatf("chosen_value %0d, expected %0d (arm %0d)",
						value, p.value, p.arm));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [Q_W-1:0]       wr_data;
	bit                   no_gaps;
	bit                   long_hold_ask;
	int                   quiet_cycles;
	bandit_tracker        tracker;

	gbvu_item_if   item_ch();
	gbvu_result_if result_ch();

	greedy_bandit_value_update dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task send_item(logic f, q_t r);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.func   <= f;
		item_ch.reward <= r;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.note_item(f, r);
	endtask

	task drain();
		item_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	task write_beat(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	// unused indexes get junk, which must change nothing
	task set_config(q_t init, logic [Q_W-1:0] step_word);
		write_beat(REG_INITIAL_VALUE, init);
		write_beat(REG_STEP_SIZE, step_word);
		write_beat(CFG_IDX_W'($urandom_range(2, 3)), Q_W'($urandom));
		wr_en <= 1'b0;
	endtask

	function automatic q_t random_reward(q_t init);
		longint near;
		case ($urandom_range(0, 7))
			0: return Q_LOW;
			1: return Q_HIGH;
			2, 3, 4: return q_t'($urandom);
			default: begin
				near = longint'(init) + longint'($urandom_range(0, 524288)) - 64'sd262144;
				if (near < longint'(Q_LOW))
					near = longint'(Q_LOW);
				if (near > longint'(Q_HIGH))
					near = longint'(Q_HIGH);
				return q_t'(near);
			end
		endcase
	endfunction

	task run_phase(q_t init, logic [Q_W-1:0] step_word, int count, bit calm);
		logic f;
		no_gaps = calm;
		set_config(init, step_word);
		send_item(FUNC_RESTART, q_t'($urandom));
		send_item(FUNC_REWARD, Q_LOW);
		send_item(FUNC_REWARD, Q_HIGH);
		for (int k = 0; k < count; k++) begin
			f = ($urandom_range(0, 11) == 0) ? FUNC_RESTART : FUNC_REWARD;
			send_item(f, random_reward(init));
		end
		drain();
	endtask

	// result side: random stalls, one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				tracker.check_pick(result_ch.chosen_arm, result_ch.chosen_value);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (long_hold_ask) begin
				long_hold_ask = 1'b0;
				stall_left = LONG_HOLD - 1;
				result_ch.ready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("greedy_bandit_value_update regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tracker        = new();
		no_gaps        = 1'b0;
		long_hold_ask  = 1'b0;
		arst_n         <= 1'b0;
		item_ch.valid  <= 1'b0;
		item_ch.func   <= FUNC_REWARD;
		item_ch.reward <= '0;
		wr_en          <= 1'b0;
		wr_index       <= REG_INITIAL_VALUE;
		wr_data        <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the first reward before any restart lands on arm 0 of the zeroed table
		send_item(FUNC_REWARD, '0);
		send_item(FUNC_REWARD, Q_HIGH);
		send_item(FUNC_REWARD, Q_LOW);
		send_item(FUNC_REWARD, q_t'(1));
		send_item(FUNC_REWARD, q_t'(-1));
		send_item(FUNC_RESTART, Q_HIGH);
		send_item(FUNC_REWARD, q_t'(24'h555555));
		send_item(FUNC_REWARD, q_t'(24'hAAAAAA));
		send_item(FUNC_REWARD, Q_HIGH);
		send_item(FUNC_REWARD, Q_HIGH);
		send_item(FUNC_RESTART, '0);
		send_item(FUNC_REWARD, Q_LOW);
		send_item(FUNC_REWARD, Q_LOW);
		drain();

		run_phase(Q_HIGH, Q_W'(65536), 89, 1'b0);
		run_phase(Q_LOW, Q_W'(131071), 89, 1'b0);
		run_phase(Q_HIGH, Q_W'(131071), 89, 1'b0);
		run_phase('0, '0, 89, 1'b0);
		long_hold_ask = 1'b1;
		run_phase(q_t'(5 << FRAC_W), Q_W'(6554), 89, 1'b0);
		run_phase(q_t'($urandom), Q_W'($urandom), 89, 1'b0);
		run_phase(q_t'($urandom), Q_W'(1), 89, 1'b0);
		run_phase(q_t'($urandom), Q_W'($urandom), 89, 1'b1);

		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0)
			$display("greedy_bandit_value_update regression: pass");
		else
			$display("greedy_bandit_value_update regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/gbvu_pkg.sv
hw/rtl/gbvu_item_if.sv
hw/rtl/gbvu_result_if.sv
hw/rtl/gbvu_cell.sv
hw/rtl/gbvu_ctrl.sv
hw/rtl/greedy_bandit_value_update.sv
tb/tb_top.sv
